@@ rtl/core/bdac_pkg.sv @@
// Shared types and constants of the binary to decimal ASCII digit unit.
// Used by bdac_controller, bdac_datapath and binary_to_decimal_ascii_digits_unit.
package bdac_pkg;

	localparam logic [5:0] ASCII_ZERO = 6'h30;
	localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
	localparam logic [3:0] BCD_ADJ = 4'd3;
	localparam int DIGIT_BITS = 4;

	typedef struct packed {
		logic load;
		logic step;
		logic shift;
	} dp_cmd_t;

	typedef struct packed {
		logic top_zero;
	} dp_status_t;

endpackage

@@ rtl/core/bdac_datapath.sv @@
// Datapath of the digit unit: shift-and-add-3 binary to BCD conversion
// and the digit shifter that presents the most significant digit.
// Depends on bdac_pkg.
module bdac_datapath #(
	parameter int VALUE_BITS = 16,
	parameter int NDIG = 5
) (
	input  logic                  clk,
	input  logic [VALUE_BITS-2:0] mag,
	input  bdac_pkg::dp_cmd_t     cmd,
	output bdac_pkg::dp_status_t  status,
	output logic [5:0]            digit_char
);

	localparam int MAG_BITS = VALUE_BITS - 1;
	localparam int BCD_BITS = NDIG * bdac_pkg::DIGIT_BITS;

	logic [MAG_BITS-1:0] bin_q;
	logic [BCD_BITS-1:0] bcd_q;
	logic [BCD_BITS-1:0] bcd_adj;
	logic [3:0]          top_digit;

	// Add 3 to every digit of five or more before the next shift.
	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			if (bcd_q[i*4 +: 4] >= bdac_pkg::BCD_ADJ_MIN)
				bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4] + bdac_pkg::BCD_ADJ;
			else
				bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bin_q <= mag;
			bcd_q <= '0;
		end else if (cmd.step) begin
			bin_q <= {bin_q[MAG_BITS-2:0], 1'b0};
			bcd_q <= {bcd_adj[BCD_BITS-2:0], bin_q[MAG_BITS-1]};
		end else if (cmd.shift) begin
			bcd_q <= {bcd_q[BCD_BITS-5:0], 4'b0000};
		end
	end

	assign top_digit = bcd_q[BCD_BITS-1 -: 4];
	assign status.top_zero = (top_digit == 4'd0);
	assign digit_char = bdac_pkg::ASCII_ZERO | {2'b00, top_digit};

endmodule

@@ rtl/core/bdac_controller.sv @@
// Controller of the digit unit: sequences conversion steps, skips leading
// zero digits and handshakes each digit out. Depends on bdac_pkg.
module bdac_controller #(
	parameter int VALUE_BITS = 16,
	parameter int NDIG = 5
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 value_valid,
	input  logic                 value_neg,
	output logic                 value_stall,
	output logic                 digit_valid,
	input  logic                 digit_stall,
	output logic                 is_last,
	output bdac_pkg::dp_cmd_t    cmd,
	input  bdac_pkg::dp_status_t status
);

	localparam int MAG_BITS = VALUE_BITS - 1;
	localparam int SW = $clog2(MAG_BITS + 1);
	localparam int DW = $clog2(NDIG + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SCAN,
		ST_EMIT
	} state_t;

	state_t         state_q;
	logic [SW-1:0]  step_cnt_q;
	logic [DW-1:0]  dig_cnt_q;
	logic           digit_valid_q;
	logic           in_take;
	logic           out_take;
	logic           last_digit;

	assign value_stall = (state_q != ST_IDLE);
	assign in_take = value_valid && !value_stall;
	assign out_take = digit_valid_q && !digit_stall;
	assign last_digit = (dig_cnt_q == DW'(1));
	assign digit_valid = digit_valid_q;
	assign is_last = last_digit;

	always_comb begin
		cmd.load = in_take && !value_neg;
		cmd.step = (state_q == ST_CONV);
		cmd.shift = 1'b0;
		case (state_q)
			ST_SCAN: cmd.shift = status.top_zero && !last_digit;
			ST_EMIT: cmd.shift = out_take && !last_digit;
			default: cmd.shift = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_cnt_q <= '0;
			dig_cnt_q <= '0;
			digit_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					// Drop negative requests without output.
					if (in_take && !value_neg) begin
						step_cnt_q <= SW'(MAG_BITS);
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					step_cnt_q <= step_cnt_q - SW'(1);
					if (step_cnt_q == SW'(1)) begin
						dig_cnt_q <= DW'(NDIG);
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (status.top_zero && !last_digit) begin
						dig_cnt_q <= dig_cnt_q - DW'(1);
					end else begin
						digit_valid_q <= 1'b1;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_take) begin
						if (last_digit) begin
							digit_valid_q <= 1'b0;
							state_q <= ST_IDLE;
						end else begin
							dig_cnt_q <= dig_cnt_q - DW'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/core/binary_to_decimal_ascii_digits_unit.sv @@
// Top level of the binary to decimal ASCII digit unit.
// Instantiates bdac_controller and bdac_datapath; depends on bdac_pkg.
//
// Usage:
//   Input channel value_valid / value_stall carries one signed value of
//   VALUE_BITS bits. A request is taken while the unit is idle.
//   Output channel digit_valid / digit_stall carries the ASCII digits of each
//   request, most significant first, no leading zeros; is_last marks the
//   least significant digit. Zero yields a single '0'. A negative value is
//   taken and yields nothing.
//   Sequence: the value is loaded, VALUE_BITS-1 shift-and-add-3 steps run,
//   leading zero digits are skipped one by one, then the first digit shows.
//   Digits then leave one per cycle while digit_stall is low.
//   A new request is not taken until the current one is done: value_stall
//   stays high until the last digit is taken.
//   A stalled receiver holds the current digit and is_last unchanged.
//   Reset clears the controller; the unit comes up idle with no output.
module binary_to_decimal_ascii_digits_unit #(
	parameter int VALUE_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  value_valid,
	output logic                  value_stall,
	input  logic [VALUE_BITS-1:0] value,
	output logic                  digit_valid,
	input  logic                  digit_stall,
	output logic [5:0]            digit_char,
	output logic                  is_last
);

	// Digits of the largest positive value: floor((VALUE_BITS-1)*log10(2)) + 1.
	localparam int NDIG = ((VALUE_BITS - 1) * 30103) / 100000 + 1;

	bdac_pkg::dp_cmd_t    cmd;
	bdac_pkg::dp_status_t status;

	bdac_controller #(
		.VALUE_BITS(VALUE_BITS),
		.NDIG(NDIG)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.value_valid(value_valid),
		.value_neg(value[VALUE_BITS-1]),
		.value_stall(value_stall),
		.digit_valid(digit_valid),
		.digit_stall(digit_stall),
		.is_last(is_last),
		.cmd(cmd),
		.status(status)
	);

	bdac_datapath #(
		.VALUE_BITS(VALUE_BITS),
		.NDIG(NDIG)
	) u_dp (
		.clk(clk),
		.mag(value[VALUE_BITS-2:0]),
		.cmd(cmd),
		.status(status),
		.digit_char(digit_char)
	);

endmodule
